[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLKED(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define RCM_ASSERT(lbl, prop, msg) `ASSERT_CLKED(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/rcm_pkg.sv]
package rcm_pkg;

  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned MA_W       = 17;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned AVG_DEPTH_DEF  = 10;
  localparam int unsigned MAX_WINDOW_DEF = 4096;

  localparam logic [MA_W-1:0]     MA_MAX          = '1;
  localparam logic [ADC_BITS-1:0] ZERO_OFFSET_RST = 12'd2048;
  localparam logic [GAIN_W-1:0]   GAIN_RST        = 24'd1320321;
  localparam logic [MA_W-1:0]     THRESHOLD_RST   = 17'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_OFFSET = 2'd0,
    CFG_GAIN        = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } rcm_cfg_idx_e;

  typedef struct packed {
    logic take_snap;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic mul_load;
    logic sat_load;
    logic avg_update;
    logic avg_scale;
    logic emit;
  } rcm_cmd_t;

  typedef struct packed {
    logic div_last;
    logic sqrt_last;
    logic out_free;
  } rcm_stat_t;

endpackage

[rtl/rcm_accum.sv]
module rcm_accum #(
  parameter int unsigned MAX_WINDOW = rcm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rcm_pkg::ADC_BITS-1:0]        sample_i,
  input  logic                                window_end_i,
  input  logic [rcm_pkg::ADC_BITS-1:0]        zero_offset_i,
  input  logic                                take_i,
  output logic                                snap_vld_o,
  output logic [2*rcm_pkg::ADC_BITS+$clog2(MAX_WINDOW+1)-1:0] snap_sum_o,
  output logic [$clog2(MAX_WINDOW+1)-1:0]     snap_cnt_o,
  output logic                                snap_full_o
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SQ_W  = 2 * rcm_pkg::ADC_BITS;
  localparam int unsigned SUM_W = SQ_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_WINDOW - 1);

  logic [rcm_pkg::ADC_BITS:0]   diff;
  logic [rcm_pkg::ADC_BITS-1:0] mag;
  logic [SQ_W-1:0]              sq;
  logic                         full_in;
  logic                         closes;
  logic                         accept;
  logic [CNT_W-1:0]             cnt_inc;
  logic [SUM_W-1:0]             sum_add;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             a_vld_q;
  logic             a_close_q;
  logic [SQ_W-1:0]  a_sq_q;
  logic [CNT_W-1:0] a_cnt_q;
  logic             a_full_q;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             snap_vld_q, snap_vld_d;
  logic [SUM_W-1:0] snap_sum_q;
  logic [CNT_W-1:0] snap_cnt_q;
  logic             snap_full_q;

  assign diff    = {1'b0, sample_i} - {1'b0, zero_offset_i};
  assign mag     = diff[rcm_pkg::ADC_BITS] ? rcm_pkg::ADC_BITS'(-diff)
                                           : diff[rcm_pkg::ADC_BITS-1:0];
  assign sq      = SQ_W'(mag) * SQ_W'(mag);
  assign full_in = (cnt_q == CNT_LAST);
  assign closes  = window_end_i | full_in;
  assign cnt_inc = cnt_q + 1'b1;
  assign sum_add = sum_q + SUM_W'(a_sq_q);

  // hold a closing beat until the snapshot slot is sure to be free
  assign in_stall_o = closes & (a_close_q | snap_vld_q);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = closes ? '0 : cnt_inc;
    end
  end

  always_comb begin
    sum_d      = sum_q;
    snap_vld_d = snap_vld_q;
    if (take_i) begin
      snap_vld_d = 1'b0;
    end
    if (a_vld_q) begin
      if (a_close_q) begin
        sum_d      = '0;
        snap_vld_d = 1'b1;
      end else begin
        sum_d = sum_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      a_vld_q    <= 1'b0;
      a_close_q  <= 1'b0;
      sum_q      <= '0;
      snap_vld_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      a_vld_q    <= accept;
      a_close_q  <= accept & closes;
      sum_q      <= sum_d;
      snap_vld_q <= snap_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sq_q   <= sq;
      a_cnt_q  <= cnt_inc;
      a_full_q <= full_in;
    end
    if (a_vld_q && a_close_q) begin
      snap_sum_q  <= sum_add;
      snap_cnt_q  <= a_cnt_q;
      snap_full_q <= a_full_q;
    end
  end

  assign snap_vld_o  = snap_vld_q;
  assign snap_sum_o  = snap_sum_q;
  assign snap_cnt_o  = snap_cnt_q;
  assign snap_full_o = snap_full_q;

endmodule

[rtl/rcm_ctrl.sv]
module rcm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               snap_vld_i,
  input  rcm_pkg::rcm_stat_t stat_i,
  output rcm_pkg::rcm_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DMEAN = 9'b000000010,
    S_SQLD  = 9'b000000100,
    S_SQRT  = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_SAT   = 9'b000100000,
    S_AVG   = 9'b001000000,
    S_DAVG  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } rcm_state_e;

  rcm_state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (snap_vld_i) begin
          cmd_o.take_snap = 1'b1;
          state_d         = S_DMEAN;
        end
      end
      S_DMEAN: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_SQLD;
        end
      end
      S_SQLD: begin
        cmd_o.sqrt_load = 1'b1;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat_load = 1'b1;
        state_d        = S_AVG;
      end
      S_AVG: begin
        cmd_o.avg_update = 1'b1;
        state_d          = S_DAVG;
      end
      S_DAVG: begin
        cmd_o.avg_scale = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/rcm_dpath.sv]
module rcm_dpath #(
  parameter int unsigned AVG_DEPTH  = rcm_pkg::AVG_DEPTH_DEF,
  parameter int unsigned MAX_WINDOW = rcm_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcm_pkg::rcm_cmd_t                   cmd_i,
  output rcm_pkg::rcm_stat_t                  stat_o,
  input  logic [2*rcm_pkg::ADC_BITS+$clog2(MAX_WINDOW+1)-1:0] snap_sum_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]     snap_cnt_i,
  input  logic                                snap_full_i,
  input  logic [rcm_pkg::GAIN_W-1:0]          gain_i,
  input  logic [rcm_pkg::MA_W-1:0]            threshold_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rcm_pkg::ADC_BITS-1:0]        rms_counts_o,
  output logic [rcm_pkg::MA_W-1:0]            current_ma_o,
  output logic [rcm_pkg::MA_W-1:0]            average_ma_o,
  output logic [rcm_pkg::MA_W-1:0]            final_ma_o,
  output logic                                window_full_o
);

  localparam int unsigned AB     = rcm_pkg::ADC_BITS;
  localparam int unsigned MA_W   = rcm_pkg::MA_W;
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SQ_W   = 2 * AB;
  localparam int unsigned DIV_W  = SQ_W + CNT_W;
  localparam int unsigned DVS_W  = CNT_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned TOT_W  = MA_W + $clog2(AVG_DEPTH);
  localparam int unsigned SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SR_W   = AB + 2;
  localparam int unsigned SC_W   = $clog2(AB);
  localparam int unsigned PROD_W = AB + rcm_pkg::GAIN_W;
  localparam int unsigned SCL_W  = PROD_W - rcm_pkg::GAIN_FRAC;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVG_DEPTH - 1);
  // floor(total / AVG_DEPTH) as a multiply by a rounded-up reciprocal
  localparam int unsigned RCP_SH = TOT_W + $clog2(AVG_DEPTH);
  localparam int unsigned RCP_W  = TOT_W + 2;
  localparam int unsigned APR_W  = TOT_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_MUL =
    RCP_W'(((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  // divider
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] dcnt_q, dcnt_d;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  div_trial;
  logic              full_q;

  // square root
  logic [SQ_W-1:0] sq_in_q;
  logic [SR_W-1:0] srem_q;
  logic [AB-1:0]   root_q;
  logic [SC_W-1:0] scnt_q;
  logic [SR_W+1:0] srem_sh;
  logic [SR_W+1:0] sq_trial;

  // scaling and averaging
  logic [PROD_W-1:0]  prod_q;
  logic [SCL_W-1:0]   scaled;
  logic [MA_W-1:0]    cur_q;
  logic [MA_W-1:0]    hist_mem [AVG_DEPTH];
  logic [MA_W-1:0]    hist_rd_q;
  logic [MA_W-1:0]    old_val;
  logic [SLOT_W-1:0]  slot_q;
  logic               wrap_q;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [APR_W-1:0]   avg_prod;
  logic [MA_W-1:0]    avg_q;
  logic [MA_W-1:0]    avg_val;

  // result register
  logic            out_valid_q;
  logic            out_free;
  logic [AB-1:0]   rms_out_q;
  logic [MA_W-1:0] cur_out_q;
  logic [MA_W-1:0] avg_out_q;
  logic [MA_W-1:0] fin_out_q;
  logic            full_out_q;

  assign rem_sh    = {rem_q, quo_q[DIV_W-1]};
  assign div_trial = {1'b0, rem_sh} - {2'b00, dvs_q};

  assign old_val = wrap_q ? hist_rd_q : '0;
  assign total_d = total_q - TOT_W'(old_val) + TOT_W'(cur_q);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dcnt_d = dcnt_q;
    if (cmd_i.take_snap) begin
      quo_d  = snap_sum_i;
      rem_d  = '0;
      dvs_d  = DVS_W'(snap_cnt_i);
      dcnt_d = STEP_W'(DIV_W - 1);
    end else if (cmd_i.div_step) begin
      dcnt_d = dcnt_q - 1'b1;
      if (div_trial[DVS_W+1]) begin
        rem_d = rem_sh[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end else begin
        rem_d = div_trial[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    dcnt_q <= dcnt_d;
    if (cmd_i.take_snap) begin
      full_q <= snap_full_i;
    end
  end

  assign srem_sh  = {srem_q, sq_in_q[SQ_W-1:SQ_W-2]};
  assign sq_trial = (SR_W + 2)'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_load) begin
      sq_in_q <= quo_q[SQ_W-1:0];
      srem_q  <= '0;
      root_q  <= '0;
      scnt_q  <= SC_W'(AB - 1);
    end else if (cmd_i.sqrt_step) begin
      sq_in_q <= {sq_in_q[SQ_W-3:0], 2'b00};
      scnt_q  <= scnt_q - 1'b1;
      if (srem_sh >= sq_trial) begin
        srem_q <= SR_W'(srem_sh - sq_trial);
        root_q <= {root_q[AB-2:0], 1'b1};
      end else begin
        srem_q <= SR_W'(srem_sh);
        root_q <= {root_q[AB-2:0], 1'b0};
      end
    end
  end

  assign scaled = prod_q[PROD_W-1:rcm_pkg::GAIN_FRAC];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= PROD_W'(root_q) * PROD_W'(gain_i);
    end
    if (cmd_i.sat_load) begin
      cur_q <= (|scaled[SCL_W-1:MA_W]) ? rcm_pkg::MA_MAX : scaled[MA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sat_load) begin
      hist_rd_q <= hist_mem[slot_q];
    end
    if (cmd_i.avg_update) begin
      hist_mem[slot_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      wrap_q  <= 1'b0;
      total_q <= '0;
    end else if (cmd_i.avg_update) begin
      total_q <= total_d;
      if (slot_q == SLOT_LAST) begin
        slot_q <= '0;
        wrap_q <= 1'b1;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  assign avg_prod = APR_W'(total_q) * APR_W'(RCP_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_scale) begin
      avg_q <= avg_prod[RCP_SH +: MA_W];
    end
  end

  assign avg_val  = avg_q;
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rms_out_q  <= root_q;
      cur_out_q  <= cur_q;
      avg_out_q  <= avg_val;
      fin_out_q  <= (avg_val < threshold_i) ? '0 : avg_val;
      full_out_q <= full_q;
    end
  end

  assign stat_o.div_last  = (dcnt_q == '0);
  assign stat_o.sqrt_last = (scnt_q == '0);
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign rms_counts_o  = rms_out_q;
  assign current_ma_o  = cur_out_q;
  assign average_ma_o  = avg_out_q;
  assign final_ma_o    = fin_out_q;
  assign window_full_o = full_out_q;

endmodule

[rtl/rms_current_meter.sv]
// Windowed true-RMS current meter with a moving average of window results.
//
// Input channel: one 12-bit ADC sample and a window_end flag per beat, taken
// when in_valid_i is high and in_stall_o is low. Plain samples are taken every
// cycle. A beat that closes a window (window_end set, or the window reaching
// MAX_WINDOW samples) is stalled while the previous window still sits in the
// snapshot register waiting for the back end.
// Output channel: one beat per closed window, held while out_stall_i is high.
// The serial divider for the mean (one quotient bit per cycle) and the
// two-bit-per-cycle square root set the latency to out_valid_o, the average
// is a single reciprocal multiply. The back end works on one window at a
// time; the next closed window waits in the snapshot register meanwhile.
// A stalled result holds the back end; samples keep accumulating meanwhile.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 zero offset, 1 Q16 gain, 2 activity threshold); other indexes are ignored.
// Reset (rst_ni low, asynchronous) clears the window, the average history and
// the pending result, and loads the default register values.
`include "assert_macros.svh"

module rms_current_meter #(
  parameter int unsigned AVG_DEPTH  = rcm_pkg::AVG_DEPTH_DEF,
  parameter int unsigned MAX_WINDOW = rcm_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rcm_pkg::ADC_BITS-1:0]     sample_i,
  input  logic                             window_end_i,
  input  logic                             cfg_we_i,
  input  logic [rcm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rcm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rcm_pkg::ADC_BITS-1:0]     rms_counts_o,
  output logic [rcm_pkg::MA_W-1:0]         current_ma_o,
  output logic [rcm_pkg::MA_W-1:0]         average_ma_o,
  output logic [rcm_pkg::MA_W-1:0]         final_ma_o,
  output logic                             window_full_o
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = 2 * rcm_pkg::ADC_BITS + CNT_W;

  logic [rcm_pkg::ADC_BITS-1:0] zero_offset_q;
  logic [rcm_pkg::GAIN_W-1:0]   gain_q;
  logic [rcm_pkg::MA_W-1:0]     threshold_q;

  logic               snap_vld;
  logic [SUM_W-1:0]   snap_sum;
  logic [CNT_W-1:0]   snap_cnt;
  logic               snap_full;
  rcm_pkg::rcm_cmd_t  cmd;
  rcm_pkg::rcm_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= rcm_pkg::ZERO_OFFSET_RST;
      gain_q        <= rcm_pkg::GAIN_RST;
      threshold_q   <= rcm_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcm_pkg::CFG_ZERO_OFFSET: zero_offset_q <= cfg_wdata_i[rcm_pkg::ADC_BITS-1:0];
        rcm_pkg::CFG_GAIN:        gain_q        <= cfg_wdata_i[rcm_pkg::GAIN_W-1:0];
        rcm_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_wdata_i[rcm_pkg::MA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcm_accum #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .window_end_i  (window_end_i),
    .zero_offset_i (zero_offset_q),
    .take_i        (cmd.take_snap),
    .snap_vld_o    (snap_vld),
    .snap_sum_o    (snap_sum),
    .snap_cnt_o    (snap_cnt),
    .snap_full_o   (snap_full)
  );

  rcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .snap_vld_i (snap_vld),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rcm_dpath #(
    .AVG_DEPTH  (AVG_DEPTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .snap_sum_i    (snap_sum),
    .snap_cnt_i    (snap_cnt),
    .snap_full_i   (snap_full),
    .gain_i        (gain_q),
    .threshold_i   (threshold_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rms_counts_o  (rms_counts_o),
    .current_ma_o  (current_ma_o),
    .average_ma_o  (average_ma_o),
    .final_ma_o    (final_ma_o),
    .window_full_o (window_full_o)
  );

  `RCM_ASSERT(a_take_needs_snap, cmd.take_snap |-> snap_vld, "snapshot taken while empty")
  `RCM_ASSERT(a_emit_when_free, cmd.emit |-> (!out_valid_o || !out_stall_i), "result overwritten")
  `RCM_ASSERT(a_emit_then_idle, cmd.emit |=> !cmd.emit, "result emitted twice")
  `RCM_ASSERT(a_final_gated, out_valid_o |-> (final_ma_o == '0 || final_ma_o == average_ma_o), "final_ma mismatch")

endmodule

[dv/rms_current_meter_test.sv]
`timescale 1ns / 100ps

module rms_current_meter_test;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_GAP      = 11;
  localparam logic [rcm_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct packed {
    logic [rcm_pkg::ADC_BITS-1:0] rms_counts;
    logic [rcm_pkg::MA_W-1:0]     current_ma;
    logic [rcm_pkg::MA_W-1:0]     average_ma;
    logic [rcm_pkg::MA_W-1:0]     final_ma;
    logic                         window_full;
  } meter_report_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_stall_o;
  logic [rcm_pkg::ADC_BITS-1:0]   sample_i     = '0;
  logic                           window_end_i = 1'b0;
  logic                           cfg_we_i     = 1'b0;
  logic [rcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [rcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                           out_valid_o;
  logic                           out_stall_i  = 1'b0;
  logic [rcm_pkg::ADC_BITS-1:0]   rms_counts_o;
  logic [rcm_pkg::MA_W-1:0]       current_ma_o;
  logic [rcm_pkg::MA_W-1:0]       average_ma_o;
  logic [rcm_pkg::MA_W-1:0]       final_ma_o;
  logic                           window_full_o;

  rms_current_meter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .window_end_i (window_end_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rms_counts_o (rms_counts_o),
    .current_ma_o (current_ma_o),
    .average_ma_o (average_ma_o),
    .final_ma_o   (final_ma_o),
    .window_full_o(window_full_o)
  );

  logic [rcm_pkg::ADC_BITS-1:0] zero_offset_q = rcm_pkg::ZERO_OFFSET_RST;
  logic [rcm_pkg::GAIN_W-1:0]   gain_q        = rcm_pkg::GAIN_RST;
  logic [rcm_pkg::MA_W-1:0]     threshold_q   = rcm_pkg::THRESHOLD_RST;

  logic [36:0]              square_acc    = '0;
  logic [12:0]              count_acc     = '0;
  logic [rcm_pkg::MA_W-1:0] history [rcm_pkg::AVG_DEPTH_DEF];
  logic [20:0]              history_total = '0;
  int unsigned              history_slot  = 0;

  meter_report_t pending_reports[$];
  meter_report_t got, want;
  int            mismatches  = 0;
  int            stall_left  = 0;
  int            idle_cycles = 0;
  bit            tx_calm     = 1'b0;
  bit            rx_calm     = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, one;
    rem  = v;
    root = '0;
    one  = 64'h4000_0000_0000_0000;
    while (one > rem) one = one >> 2;
    while (one != 0) begin
      if (rem >= root + one) begin
        rem  = rem - (root + one);
        root = (root >> 1) + one;
      end else begin
        root = root >> 1;
      end
      one = one >> 2;
    end
    return root[31:0];
  endfunction

  task automatic track_sample(input logic [rcm_pkg::ADC_BITS-1:0] s, input logic e);
    int                       d;
    logic [36:0]              mag;
    logic [36:0]              mean;
    logic [31:0]              root;
    logic [35:0]              prod;
    logic [rcm_pkg::MA_W-1:0] cur;
    logic [20:0]              avg;
    logic                     full;
    meter_report_t            r;
    d   = int'(s) - int'(zero_offset_q);
    mag = (d < 0) ? 37'(-d) : 37'(d);
    square_acc = square_acc + mag * mag;
    count_acc  = count_acc + 1'b1;
    full = (count_acc >= rcm_pkg::MAX_WINDOW_DEF);
    if (!full && !e) return;
    mean = square_acc / count_acc;
    root = floor_sqrt(64'(mean));
    prod = (36'(root[rcm_pkg::ADC_BITS-1:0]) * 36'(gain_q)) >> rcm_pkg::GAIN_FRAC;
    cur  = (prod > 36'(rcm_pkg::MA_MAX)) ? rcm_pkg::MA_MAX : prod[rcm_pkg::MA_W-1:0];
    history_total = history_total - history[history_slot] + cur;
    history[history_slot] = cur;
    history_slot = (history_slot + 1) % rcm_pkg::AVG_DEPTH_DEF;
    avg = 21'(history_total / rcm_pkg::AVG_DEPTH_DEF);
    r.rms_counts  = root[rcm_pkg::ADC_BITS-1:0];
    r.current_ma  = cur;
    r.average_ma  = avg[rcm_pkg::MA_W-1:0];
    r.final_ma    = (avg[rcm_pkg::MA_W-1:0] < threshold_q) ? '0 : avg[rcm_pkg::MA_W-1:0];
    r.window_full = full;
    pending_reports.push_back(r);
    square_acc = '0;
    count_acc  = '0;
  endtask

  task automatic send_beat(input logic [rcm_pkg::ADC_BITS-1:0] s, input logic e);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= s;
    window_end_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    track_sample(s, e);
  endtask

  task automatic write_reg(input logic [rcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rcm_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      rcm_pkg::CFG_ZERO_OFFSET: zero_offset_q = data[rcm_pkg::ADC_BITS-1:0];
      rcm_pkg::CFG_GAIN:        gain_q        = data[rcm_pkg::GAIN_W-1:0];
      rcm_pkg::CFG_THRESHOLD:   threshold_q   = data[rcm_pkg::MA_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle_meter();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [rcm_pkg::ADC_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return zero_offset_q + rcm_pkg::ADC_BITS'($urandom_range(0, 64))
                      - rcm_pkg::ADC_BITS'(32);
      default: return rcm_pkg::ADC_BITS'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_beat(12'd2048, 1'b1);
    send_beat(12'd0,    1'b1);
    send_beat(12'd4095, 1'b1);
    send_beat(12'd0,    1'b0);
    send_beat(12'd4095, 1'b1);
    send_beat(12'd2047, 1'b0);
    send_beat(12'd2049, 1'b0);
    send_beat(12'd2048, 1'b1);
    settle_meter();
  endtask

  task automatic test_register_limits();
    write_reg(rcm_pkg::CFG_ZERO_OFFSET, 24'hFFF000);
    write_reg(rcm_pkg::CFG_GAIN, 24'hFFFFFF);
    write_reg(rcm_pkg::CFG_THRESHOLD, 24'hFE0000);
    send_beat(12'd4095, 1'b1);
    send_beat(12'd0, 1'b1);
    settle_meter();
    write_reg(CFG_SPARE_IDX, 24'hFFFFFF);
    send_beat(12'd4095, 1'b1);
    settle_meter();
    write_reg(rcm_pkg::CFG_THRESHOLD, 24'hFFFFFF);
    send_beat(12'd4095, 1'b1);
    settle_meter();
    write_reg(rcm_pkg::CFG_ZERO_OFFSET, 24'h000FFF);
    write_reg(rcm_pkg::CFG_GAIN, 24'h000000);
    send_beat(12'd0, 1'b1);
    send_beat(12'd4095, 1'b1);
    settle_meter();
    write_reg(rcm_pkg::CFG_ZERO_OFFSET, rcm_pkg::CFG_DATA_W'(rcm_pkg::ZERO_OFFSET_RST));
    write_reg(rcm_pkg::CFG_GAIN, rcm_pkg::CFG_DATA_W'(rcm_pkg::GAIN_RST));
    write_reg(rcm_pkg::CFG_THRESHOLD, rcm_pkg::CFG_DATA_W'(rcm_pkg::THRESHOLD_RST));
  endtask

  task automatic test_full_window();
    logic last_end;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    write_reg(rcm_pkg::CFG_ZERO_OFFSET, 24'h000000);
    last_end = 1'($urandom_range(0, 1));
    for (int i = 0; i < rcm_pkg::MAX_WINDOW_DEF; i++)
      send_beat(rcm_pkg::ADC_BITS'($urandom),
                (i == rcm_pkg::MAX_WINDOW_DEF - 1) ? last_end : 1'b0);
    settle_meter();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_windows(input int total_items);
    int sent;
    int len;
    logic [rcm_pkg::CFG_DATA_W-1:0] data;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 3))
        0:       data = {12'($urandom), 12'd0};
        1:       data = {12'($urandom), 12'd4095};
        2:       data = {12'($urandom), 12'd2048};
        default: data = rcm_pkg::CFG_DATA_W'($urandom);
      endcase
      write_reg(rcm_pkg::CFG_ZERO_OFFSET, data);
      case ($urandom_range(0, 3))
        0:       data = 24'hFFFFFF;
        1:       data = 24'h000000;
        2:       data = rcm_pkg::CFG_DATA_W'(rcm_pkg::GAIN_RST)
                        + rcm_pkg::CFG_DATA_W'($urandom_range(0, 4095));
        default: data = rcm_pkg::CFG_DATA_W'($urandom);
      endcase
      write_reg(rcm_pkg::CFG_GAIN, data);
      case ($urandom_range(0, 3))
        0:       data = {7'($urandom), 17'd0};
        1:       data = {7'($urandom), 17'h1FFFF};
        default: data = {7'($urandom), 17'($urandom_range(0, 60000))};
      endcase
      write_reg(rcm_pkg::CFG_THRESHOLD, data);
      write_reg(CFG_SPARE_IDX, rcm_pkg::CFG_DATA_W'($urandom));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < total_items / 6) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_beat(pick_sample(), i == len - 1);
          sent++;
        end
      end
      settle_meter();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.rms_counts  = rms_counts_o;
        got.current_ma  = current_ma_o;
        got.average_ma  = average_ma_o;
        got.final_ma    = final_ma_o;
        got.window_full = window_full_o;
        if (pending_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected beat: rms %0d cur %0d avg %0d fin %0d full %0b",
                     got.rms_counts, got.current_ma, got.average_ma, got.final_ma,
                     got.window_full);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (got.rms_counts !== want.rms_counts || got.current_ma !== want.current_ma ||
              got.average_ma !== want.average_ma || got.final_ma !== want.final_ma ||
              got.window_full !== want.window_full) begin
            if (mismatches < 10)
              $display({"beat mismatch: exp rms %0d cur %0d avg %0d fin %0d full %0b, ",
                        "got rms %0d cur %0d avg %0d fin %0d full %0b"},
                       want.rms_counts, want.current_ma, want.average_ma, want.final_ma,
                       want.window_full, got.rms_counts, got.current_ma, got.average_ma,
                       got.final_ma, got.window_full);
            mismatches++;
          end
        end
        stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    foreach (history[k]) history[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_register_limits();
    test_full_window();
    test_random_windows(750);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
